>>> rtl/core/tcrb_pkg.sv
// Shared types and codes of the transmit chunk ring buffer.
package tcrb_pkg;

   // Result code of a write item.
   typedef enum logic [1:0] {
      WR_OK       = 2'd0,
      WR_DISCARD  = 2'd1,
      WR_OVERFLOW = 2'd2
   } wr_status_type;

endpackage

>>> rtl/core/tx_chunk_ring_buffer_unit.sv
// Transmit byte ring with a queue of chunk end marks, one item per cycle.
//
// The block takes one item in every clock cycle (busy is high only while reset is
// held) and shows its result on the rsp_ ports in the cycle after the item
// was taken, marked by rsp_strobe; the receiver cannot stall it. The drained
// byte comes from the registered read port of the store: a drain item reads the
// store at the read pointer in its accept cycle and the byte appears with the
// strobe. Write items store one byte at the pending pointer and commit a segment
// at the end of a write, at the buffer end, or at the freed tail; a segment
// extends the newest chunk or opens a new chunk in the end-mark queue. The queue
// keeps its end marks in a small memory; the end marks of the oldest and newest
// chunk are held in registers, and the next oldest one is fetched when a chunk
// is freed, ready for the following cycle. The byte store has no reset and no
// clearing pass: only committed bytes are ever read.
module tx_chunk_ring_buffer_unit #(
   parameter int unsigned BUF_DEPTH   = 1024,
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_of_write,
   output logic       rsp_strobe,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_chunk,
   output logic [1:0] rsp_write_status
);
   import tcrb_pkg::*;

   localparam int unsigned AW       = $clog2(BUF_DEPTH);
   localparam int unsigned QW       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QLastInt = QUEUE_DEPTH - 1;
   localparam logic [AW:0]   BUF_END = BUF_DEPTH[AW:0];
   localparam logic [QW-1:0] Q_LAST  = QLastInt[QW-1:0];

   // Next and previous slot of the end-mark queue, wrapping at its depth.
   function automatic logic [QW-1:0] q_next(input logic [QW-1:0] idx);
      q_next = (idx == Q_LAST) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [QW-1:0] q_prev(input logic [QW-1:0] idx);
      q_prev = (idx == '0) ? Q_LAST : idx - 1'b1;
   endfunction

   // Ring pointers and queue state.
   logic [AW-1:0] committed_ff, committed_in;
   logic [AW-1:0] pending_ff, pending_in;
   logic [AW-1:0] freed_ff, freed_in;
   logic [AW-1:0] rdptr_ff, rdptr_in;
   logic [QW-1:0] qhead_ff, qhead_in;
   logic [QW-1:0] qtail_ff, qtail_in;
   logic          discard_ff, discard_in;
   logic [AW-1:0] tail_end_ff, tail_end_in;
   logic [AW-1:0] newest_end_ff, newest_end_in;
   logic          tail_load_ff, tail_load_in;

   // Result registers.
   logic          rsp_strobe_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_eoc_ff, rsp_eoc_in;
   wr_status_type rsp_status_ff, rsp_status_in;

   // Memories and their read registers.
   logic [7:0]    store_mem [BUF_DEPTH];
   logic [7:0]    store_rd_ff;
   logic [AW-1:0] end_mem [QUEUE_DEPTH];
   logic [AW-1:0] tbl_rd_ff;
   logic          store_we;
   logic          tbl_we;
   logic [QW-1:0] tbl_waddr;

   logic          accept;
   logic          q_empty;
   logic          q_full;
   logic          can_extend;
   logic          buf_full;
   logic [AW:0]   p1;
   logic [AW:0]   limit;
   logic          cut;
   logic [AW-1:0] seg_end;
   logic [AW-1:0] tail_end;
   logic [AW:0]   rp1;
   logic          drain_eoc;

   // Items are refused only while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;

   // Queue status; the end mark of the oldest chunk may just have been fetched.
   assign q_empty    = (qhead_ff == qtail_ff);
   assign q_full     = (q_next(qhead_ff) == qtail_ff);
   assign can_extend = !q_empty && (q_next(qtail_ff) != qhead_ff) && (newest_end_ff != '0);
   assign tail_end   = tail_load_ff ? tbl_rd_ff : tail_end_ff;

   // Write path: full check, segment cut and the end mark of the segment.
   assign buf_full = (pending_ff == committed_ff) && (committed_ff == freed_ff) && !q_empty;
   assign p1       = {1'b0, pending_ff} + 1'b1;
   assign limit    = (committed_ff < freed_ff) ? {1'b0, freed_ff} : BUF_END;
   assign cut      = (p1 >= limit);
   assign seg_end  = (p1 == BUF_END) ? '0 : p1[AW-1:0];

   // Drain path: an end mark of zero stands for the buffer end.
   assign rp1       = {1'b0, rdptr_ff} + 1'b1;
   assign drain_eoc = (tail_end == '0) ? (rp1 == BUF_END) : (rp1 >= {1'b0, tail_end});

   // Next state of one item.
   always_comb begin
      committed_in  = committed_ff;
      pending_in    = pending_ff;
      freed_in      = freed_ff;
      rdptr_in      = rdptr_ff;
      qhead_in      = qhead_ff;
      qtail_in      = qtail_ff;
      discard_in    = discard_ff;
      tail_end_in   = tail_end;
      newest_end_in = newest_end_ff;
      tail_load_in  = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_eoc_in    = 1'b0;
      rsp_status_in = WR_OK;
      store_we      = 1'b0;
      tbl_we        = 1'b0;
      tbl_waddr     = qhead_ff;
      if (accept) begin
         if (!req_action) begin
            if (discard_ff || buf_full) begin
               rsp_status_in = WR_DISCARD;
               discard_in    = !req_last_of_write;
            end else begin
               store_we = 1'b1;
               if (req_last_of_write || cut) begin
                  if (can_extend) begin
                     tbl_we        = 1'b1;
                     tbl_waddr     = q_prev(qhead_ff);
                     newest_end_in = seg_end;
                     committed_in  = seg_end;
                     pending_in    = seg_end;
                  end else if (q_full) begin
                     pending_in    = committed_ff;
                     rsp_status_in = WR_OVERFLOW;
                     discard_in    = !req_last_of_write;
                  end else begin
                     tbl_we        = 1'b1;
                     tbl_waddr     = qhead_ff;
                     qhead_in      = q_next(qhead_ff);
                     newest_end_in = seg_end;
                     committed_in  = seg_end;
                     pending_in    = seg_end;
                     if (q_empty) begin
                        tail_end_in = seg_end;
                     end
                  end
               end else begin
                  pending_in = p1[AW-1:0];
               end
            end
         end else if (!q_empty) begin
            rsp_valid_in = 1'b1;
            if (drain_eoc) begin
               rsp_eoc_in   = 1'b1;
               freed_in     = tail_end;
               rdptr_in     = tail_end;
               qtail_in     = q_next(qtail_ff);
               tail_load_in = 1'b1;
            end else begin
               rdptr_in = rp1[AW-1:0];
            end
         end
      end
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff  <= '0;
         pending_ff    <= '0;
         freed_ff      <= '0;
         rdptr_ff      <= '0;
         qhead_ff      <= '0;
         qtail_ff      <= '0;
         discard_ff    <= 1'b0;
         tail_end_ff   <= '0;
         newest_end_ff <= '0;
         tail_load_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_eoc_ff    <= 1'b0;
         rsp_status_ff <= WR_OK;
      end else begin
         committed_ff  <= committed_in;
         pending_ff    <= pending_in;
         freed_ff      <= freed_in;
         rdptr_ff      <= rdptr_in;
         qhead_ff      <= qhead_in;
         qtail_ff      <= qtail_in;
         discard_ff    <= discard_in;
         tail_end_ff   <= tail_end_in;
         newest_end_ff <= newest_end_in;
         tail_load_ff  <= tail_load_in;
         rsp_strobe_ff <= accept;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_eoc_ff    <= rsp_eoc_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // Byte store: written at the pending pointer, read at the read pointer.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[pending_ff] <= req_data_byte;
      end
      store_rd_ff <= store_mem[rdptr_ff];
   end

   // End-mark table: the slot after the oldest is read for the next oldest chunk.
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         end_mem[tbl_waddr] <= seg_end;
      end
      tbl_rd_ff <= end_mem[q_next(qtail_ff)];
   end

   // Result ports.
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_tx_byte      = rsp_valid_ff ? store_rd_ff : 8'd0;
   assign rsp_byte_valid   = rsp_valid_ff;
   assign rsp_end_of_chunk = rsp_eoc_ff;
   assign rsp_write_status = rsp_status_ff;

endmodule

>>> rtl/core/tcrb_checker.sv
// Port-level checks of the transmit chunk ring buffer and their binding.
module tcrb_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_action,
   input logic       rsp_strobe,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_end_of_chunk,
   input logic [1:0] rsp_write_status
);
   import tcrb_pkg::*;

   // Every accepted item gets its result in the next cycle.
   a_rsp_follows_item: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted item got no result");

   // No result appears without an item taken the cycle before.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without an accepted item");

   // A write item reports no drained byte.
   a_write_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !$past(req_action)) |->
         (!rsp_byte_valid && !rsp_end_of_chunk && rsp_tx_byte == 8'd0))
      else $error("write item reported drain fields");

   // A drain item reports an accepted status, and an empty drain carries no byte.
   a_drain_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_action)) |->
         (rsp_write_status == WR_OK &&
          (rsp_byte_valid || (!rsp_end_of_chunk && rsp_tx_byte == 8'd0))))
      else $error("drain item reported bad fields");

   // A chunk end is only ever reported with a drained byte.
   a_eoc_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_end_of_chunk |-> (rsp_strobe && rsp_byte_valid))
      else $error("chunk end without a drained byte");

endmodule

bind tx_chunk_ring_buffer_unit tcrb_checker u_tcrb_checker (.*);
